// ===== rtl/lzhc_pkg.sv =====
// Shared types, constants and prefix-code functions for the LZ hash-chain encoder.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none
package lzhc_pkg;

  localparam int DEF_WINDOW_SIZE = 4096;
  localparam int DEF_MAX_MATCH   = 226;
  localparam int PAIR_TABLE_SIZE = 1024;
  localparam int PAIR_W          = 10;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 8;
  localparam int SHIFT_W         = 12;
  localparam int CODE_W          = 27;
  localparam int CNT_W           = 5;

  localparam logic TOK_LIT   = 1'b0;
  localparam logic TOK_MATCH = 1'b1;

  // length code tiers
  localparam int LEN_TIER_A = 34;
  localparam int LEN_TIER_B = 34 + 64;
  // shift code tiers
  localparam int SH_TIER_A = 34;
  localparam int SH_TIER_B = 34 + 64;
  localparam int SH_TIER_C = 34 + 64 + 256;
  localparam int SH_TIER_D = 34 + 64 + 256 + 1024;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic [BYTE_W-1:0]  lit;
    logic [LEN_W-1:0]   len;
    logic [SHIFT_W-1:0] shift;
    logic               last;
  } tok_t;

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [CNT_W-1:0]  cnt;
  } code_t;

  function automatic code_t length_code(input logic [LEN_W-1:0] len);
    code_t c;
    logic [LEN_W-1:0] e;
    c.bits = '0;
    c.cnt  = '0;
    e      = '0;
    if (len <= 8'd2) begin
      c.bits = 27'd1;  c.cnt = 5'd3;
    end else if (len == 8'd3) begin
      c.bits = 27'd3;  c.cnt = 5'd5;
    end else if (len == 8'd4) begin
      c.bits = 27'd5;  c.cnt = 5'd3;
    end else if (len == 8'd5) begin
      c.bits = 27'd7;  c.cnt = 5'd5;
    end else if (len == 8'd6) begin
      c.bits = 27'd15; c.cnt = 5'd5;
    end else if (len <= 8'd10) begin
      e = len - 8'd7;
      c.bits = 27'd11 | (CODE_W'(e[1:0]) << 4); c.cnt = 5'd6;
    end else if (len <= 8'd18) begin
      e = len - 8'd11;
      c.bits = 27'd19 | (CODE_W'(e[2:0]) << 5); c.cnt = 5'd8;
    end else if (len <= LEN_W'(LEN_TIER_A)) begin
      e = len - 8'd19;
      c.bits = 27'd31 | (CODE_W'(e[3:0]) << 6); c.cnt = 5'd10;
    end else if (len <= LEN_W'(LEN_TIER_B)) begin
      e = len - 8'd35;
      c.bits = 27'd23 | (CODE_W'(e[5:0]) << 5); c.cnt = 5'd11;
    end else begin
      e = len - 8'd99;
      c.bits = 27'd63 | (CODE_W'(e[6:0]) << 6); c.cnt = 5'd13;
    end
    return c;
  endfunction

  function automatic code_t shift_code(input logic [SHIFT_W-1:0] s);
    code_t c;
    logic [SHIFT_W-1:0] d;
    c.bits = '0;
    c.cnt  = '0;
    d      = '0;
    if (s < 12'd2) begin
      c.bits = 27'd28 | (CODE_W'(s[0]) << 5); c.cnt = 5'd6;
    end else if (s < 12'd6) begin
      d = s - 12'd2;
      c.bits = 27'd8 | (CODE_W'(d[1:0]) << 4); c.cnt = 5'd6;
    end else if (s < 12'd10) begin
      d = s - 12'd6;
      c.bits = 27'd4 | (CODE_W'(d[1:0]) << 4); c.cnt = 5'd6;
    end else if (s < 12'd18) begin
      d = s - 12'd10;
      c.bits = CODE_W'(d[2:0]) << 4; c.cnt = 5'd7;
    end else if (s < SHIFT_W'(SH_TIER_A)) begin
      d = s - 12'd18;
      c.bits = 27'd12 | (CODE_W'(d[3:0]) << 5); c.cnt = 5'd9;
    end else if (s < SHIFT_W'(SH_TIER_B)) begin
      d = s - SHIFT_W'(SH_TIER_A);
      c.bits = 27'd2 | (CODE_W'(d[5:0]) << 3); c.cnt = 5'd9;
    end else if (s < SHIFT_W'(SH_TIER_C)) begin
      d = s - SHIFT_W'(SH_TIER_B);
      c.bits = 27'd6 | (CODE_W'(d[7:0]) << 3); c.cnt = 5'd11;
    end else if (s < SHIFT_W'(SH_TIER_D)) begin
      d = s - SHIFT_W'(SH_TIER_C);
      c.bits = 27'd3 | (CODE_W'(d[9:0]) << 2); c.cnt = 5'd12;
    end else begin
      d = s - SHIFT_W'(SH_TIER_D);
      c.bits = 27'd1 | (CODE_W'(d) << 2); c.cnt = 5'd14;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lzhc_queue.sv =====
// Front side: two-entry input queue that takes byte transfers and hands them to the engine.
// Depends on lzhc_pkg for the queued item type.
`default_nettype none
module lzhc_queue (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire lzhc_pkg::item_t                   in_item,
  output logic                                   q_valid,
  input  wire logic                              q_pop,
  output lzhc_pkg::item_t                        q_item
);

  lzhc_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lzhc_engine.sv =====
// Back side: window, pair-head and chain memories plus the sequencer that extends matches,
// walks hash chains and issues tokens. Depends on lzhc_pkg.
`default_nettype none
module lzhc_engine #(
  parameter int WINDOW_SIZE = lzhc_pkg::DEF_WINDOW_SIZE,
  parameter int MAX_MATCH   = lzhc_pkg::DEF_MAX_MATCH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire lzhc_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 em_push,
  input  wire logic            em_ready,
  output lzhc_pkg::tok_t       tok
);

  localparam int AW    = $clog2(WINDOW_SIZE);
  localparam int SW    = AW + 1;
  localparam int S1W   = AW + 2;
  localparam int PT    = lzhc_pkg::PAIR_TABLE_SIZE;
  localparam int CLR_N = (WINDOW_SIZE > PT) ? WINDOW_SIZE : PT;
  localparam int CW    = $clog2(CLR_N);
  localparam int SL    = WINDOW_SIZE - MAX_MATCH - 1;
  localparam int LW    = lzhc_pkg::LEN_W;
  localparam int BW    = lzhc_pkg::BYTE_W;
  localparam int PAIR_W_L = lzhc_pkg::PAIR_W;

  localparam logic [4:0] ST_CLEAR  = 5'd0;
  localparam logic [4:0] ST_IDLE   = 5'd1;
  localparam logic [4:0] ST_UPD    = 5'd2;
  localparam logic [4:0] ST_BR     = 5'd3;
  localparam logic [4:0] ST_LITOUT = 5'd4;
  localparam logic [4:0] ST_LITCK  = 5'd5;
  localparam logic [4:0] ST_EXTCK  = 5'd6;
  localparam logic [4:0] ST_WSINIT = 5'd7;
  localparam logic [4:0] ST_WOUT   = 5'd8;
  localparam logic [4:0] ST_WIN    = 5'd9;
  localparam logic [4:0] ST_WS1    = 5'd10;
  localparam logic [4:0] ST_WSH    = 5'd11;
  localparam logic [4:0] ST_CMPRD  = 5'd12;
  localparam logic [4:0] ST_CMPCK  = 5'd13;
  localparam logic [4:0] ST_ADVS   = 5'd14;
  localparam logic [4:0] ST_ADVS1  = 5'd15;
  localparam logic [4:0] ST_TAIL   = 5'd16;
  localparam logic [4:0] ST_PUSH   = 5'd17;

  logic [BW-1:0] hist_mem  [WINDOW_SIZE];
  logic [AW-1:0] head_mem  [PT];
  logic [SW-1:0] chain_mem [WINDOW_SIZE];

  logic [4:0]    state;
  logic [4:0]    ret;
  logic [CW-1:0] clr_cnt;
  logic [AW-1:0] wp;
  logic          mact;
  logic [AW-1:0] ms;
  logic [LW-1:0] ml;
  logic [BW-1:0] prev;
  logic          first;
  logic [BW-1:0] cur_c;
  logic          cur_last;
  logic [AW-1:0] pprev;
  logic [SW-1:0] dif_r;
  logic [SW-1:0] shift;
  logic [S1W-1:0] s1;
  logic [AW-1:0] cand;
  logic [AW-1:0] rel;
  logic [LW-1:0] idx;

  logic [BW-1:0] hist_qa, hist_qb;
  logic [AW-1:0] head_q;
  logic [SW-1:0] chain_q;

  logic          hist_we, head_we, chain_we;
  logic [AW-1:0] hist_wa, hist_ra, hist_rb, chain_wa, chain_ra;
  logic [BW-1:0] hist_wd;
  logic [PAIR_W_L-1:0] head_wa, head_ra;
  logic [AW-1:0] head_wd;
  logic [SW-1:0] chain_wd;

  logic [AW-1:0] cand_n;
  logic [AW-1:0] dif_raw;
  logic [SW-1:0] dif;
  logic [S1W-1:0] shift_x;
  logic          first_lit;
  logic [AW-1:0] rel_ms;

  function automatic lzhc_pkg::tok_t mk_lit(input logic [BW-1:0] b, input logic l);
    lzhc_pkg::tok_t t;
    t.kind  = lzhc_pkg::TOK_LIT;
    t.lit   = b;
    t.len   = '0;
    t.shift = '0;
    t.last  = l;
    return t;
  endfunction

  function automatic lzhc_pkg::tok_t mk_match(input logic [AW-1:0] w, input logic [AW-1:0] src,
                                              input logic [LW-1:0] l, input logic lf);
    lzhc_pkg::tok_t t;
    logic [AW-1:0] s;
    s       = w - src - AW'(l) - AW'(1);
    t.kind  = lzhc_pkg::TOK_MATCH;
    t.lit   = '0;
    t.len   = l;
    t.shift = lzhc_pkg::SHIFT_W'(s);
    t.last  = lf;
    return t;
  endfunction

  assign cand_n    = pprev - shift[AW-1:0];
  assign dif_raw   = wp - head_q;
  assign dif       = (dif_raw == '0) ? SW'(WINDOW_SIZE) : SW'(dif_raw);
  assign shift_x   = S1W'(shift);
  assign rel_ms    = rel - ms;
  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign em_push   = (state == ST_PUSH) && em_ready;
  assign first_lit = q_pop && !first;

  // memory port steering
  always_comb begin
    head_ra  = {prev, 2'b00} ^ PAIR_W_L'(q_item.data);
    head_wa  = {prev, 2'b00} ^ PAIR_W_L'(cur_c);
    head_wd  = wp;
    head_we  = (state == ST_UPD);
    hist_we  = first_lit || (state == ST_UPD);
    hist_wa  = wp + AW'(1);
    hist_wd  = (state == ST_UPD) ? cur_c : q_item.data;
    chain_we = first_lit || (state == ST_UPD);
    chain_wa = wp;
    chain_wd = (state == ST_UPD) ? dif : SW'(WINDOW_SIZE);
    hist_ra  = cand_n;
    hist_rb  = cand_n + AW'(1);
    chain_ra = cand_n;
    case (state)
      ST_CLEAR: begin
        hist_we = 1'b1;
        hist_wa = AW'(clr_cnt);
        hist_wd = '0;
        head_we = 1'b1;
        head_wa = clr_cnt[PAIR_W_L-1:0];
        head_wd = '0;
      end
      ST_BR:    hist_ra = ms + AW'(ml);
      ST_EXTCK: chain_ra = ms;
      ST_WIN:   chain_ra = (shift_x > s1) ? (pprev - s1[AW-1:0]) : (rel - shift[AW-1:0]);
      ST_CMPRD: begin
        hist_ra = cand + AW'(idx);
        hist_rb = rel + AW'(idx);
      end
      ST_CMPCK: chain_ra = cand;
      ST_ADVS:  chain_ra = pprev - s1[AW-1:0];
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    hist_qa <= hist_mem[hist_ra];
    hist_qb <= hist_mem[hist_rb];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (chain_we) chain_mem[chain_wa] <= chain_wd;
    chain_q <= chain_mem[chain_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      ret     <= ST_IDLE;
      clr_cnt <= '0;
      wp      <= '0;
      mact    <= 1'b0;
      ms      <= '0;
      ml      <= '0;
      prev    <= '0;
      first   <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + CW'(1);
          if (clr_cnt == CW'(CLR_N - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur_c    <= q_item.data;
            cur_last <= q_item.last;
            if (!first) begin
              wp   <= wp + AW'(1);
              prev <= q_item.data;
              mact <= 1'b0;
              if (q_item.last) begin
                tok   <= mk_lit(q_item.data, 1'b1);
                ret   <= ST_IDLE;
                state <= ST_PUSH;
              end else begin
                first <= 1'b1;
              end
            end else begin
              state <= ST_UPD;
            end
          end
        end
        ST_UPD: begin
          pprev <= wp;
          wp    <= wp + AW'(1);
          dif_r <= dif;
          state <= ST_BR;
        end
        ST_BR: begin
          if (!mact) begin
            shift <= dif_r;
            state <= ST_LITOUT;
          end else if (ml < LW'(MAX_MATCH)) begin
            state <= ST_EXTCK;
          end else begin
            tok   <= mk_match(wp, ms, ml, 1'b0);
            mact  <= 1'b0;
            ret   <= ST_TAIL;
            state <= ST_PUSH;
          end
        end
        ST_LITOUT: begin
          if (shift < SW'(SL)) begin
            cand  <= cand_n;
            state <= ST_LITCK;
          end else begin
            tok   <= mk_lit(prev, 1'b0);
            ret   <= ST_TAIL;
            state <= ST_PUSH;
          end
        end
        ST_LITCK: begin
          if (hist_qa == prev && hist_qb == cur_c) begin
            ms    <= cand;
            ml    <= LW'(2);
            mact  <= 1'b1;
            state <= ST_TAIL;
          end else begin
            shift <= shift + chain_q;
            state <= ST_LITOUT;
          end
        end
        ST_EXTCK: begin
          if (hist_qa == cur_c) begin
            ml    <= ml + LW'(1);
            state <= ST_TAIL;
          end else begin
            rel   <= wp - AW'(ml);
            s1    <= S1W'(dif_r);
            state <= ST_WSINIT;
          end
        end
        ST_WSINIT: begin
          shift <= SW'(rel_ms) + chain_q;
          state <= ST_WOUT;
        end
        ST_WOUT: begin
          if (shift < SW'(SL)) begin
            state <= ST_WIN;
          end else begin
            tok   <= mk_match(wp, ms, ml, 1'b0);
            mact  <= 1'b0;
            ret   <= ST_TAIL;
            state <= ST_PUSH;
          end
        end
        ST_WIN: begin
          if (shift_x > s1) begin
            state <= ST_WS1;
          end else if (shift_x < s1) begin
            state <= ST_WSH;
          end else begin
            cand  <= rel - shift[AW-1:0];
            idx   <= '0;
            state <= ST_CMPRD;
          end
        end
        ST_WS1: begin
          s1    <= s1 + S1W'(chain_q);
          state <= ST_WIN;
        end
        ST_WSH: begin
          shift <= shift + chain_q;
          state <= ST_WOUT;
        end
        ST_CMPRD: state <= ST_CMPCK;
        ST_CMPCK: begin
          if (hist_qa != hist_qb) begin
            state <= ST_ADVS;
          end else if (idx == ml) begin
            ms    <= cand;
            ml    <= ml + LW'(1);
            state <= ST_TAIL;
          end else begin
            idx   <= idx + LW'(1);
            state <= ST_CMPRD;
          end
        end
        ST_ADVS: begin
          shift <= shift + chain_q;
          state <= ST_ADVS1;
        end
        ST_ADVS1: begin
          s1    <= s1 + S1W'(chain_q);
          state <= ST_WOUT;
        end
        ST_TAIL: begin
          prev <= cur_c;
          if (cur_last) begin
            tok   <= mact ? mk_match(wp, ms - AW'(1), ml, 1'b1) : mk_lit(cur_c, 1'b1);
            first <= 1'b0;
            mact  <= 1'b0;
            ret   <= ST_IDLE;
            state <= ST_PUSH;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_PUSH: begin
          if (em_ready) state <= ret;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lzhc_emit.sv =====
// Token coder and two-entry output buffer: builds the prefix code of each token and
// holds it until the master side takes the transfer. Depends on lzhc_pkg.
`default_nettype none
module lzhc_emit (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           em_push,
  output logic                em_ready,
  input  wire lzhc_pkg::tok_t tok,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [63:0]         out_data,
  output logic                out_last
);

  typedef struct packed {
    lzhc_pkg::tok_t t;
    lzhc_pkg::code_t c;
  } entry_t;

  entry_t          slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            pop;
  lzhc_pkg::code_t lc, sc, code;
  entry_t          head;

  always_comb begin
    lc = lzhc_pkg::length_code(tok.len);
    sc = lzhc_pkg::shift_code(tok.shift);
    if (tok.kind == lzhc_pkg::TOK_LIT) begin
      code.bits = lzhc_pkg::CODE_W'(tok.lit) << 1;
      code.cnt  = lzhc_pkg::CNT_W'(9);
    end else begin
      code.bits = lc.bits | (sc.bits << lc.cnt);
      code.cnt  = lc.cnt + sc.cnt;
    end
  end

  assign em_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign head      = slots[rd_ptr];
  assign out_last  = head.t.last;
  assign out_data  = {3'b000, head.c.cnt, head.c.bits, head.t.shift, head.t.len,
                      head.t.lit, head.t.kind};

  always_ff @(posedge clk) begin
    if (em_push) begin
      slots[wr_ptr] <= '{t: tok, c: code};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (em_push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(em_push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lz_hash_chain_encoder.sv =====
// Each input byte runs through the sequencer on its own: it extends a match, or walks the
// hash chain once to test candidates, or walks the chain a second time with catch-up
// steps and compares candidate copies byte by byte, and it pushes a token when one is due;
// the engine takes no new byte until the last one is through, so one byte is in work at a
// time and the rate is data dependent.
// Reset: synchronous; window and pair heads are cleared after reset, before the engine takes a byte.
`default_nettype none
module lz_hash_chain_encoder #(
  parameter int WINDOW_SIZE = lzhc_pkg::DEF_WINDOW_SIZE,
  parameter int MAX_MATCH   = lzhc_pkg::DEF_MAX_MATCH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic        s_axis_tlast,  // last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // [0] token_kind, [8:1] literal_value,
                                          // [16:9] match_length, [28:17] match_shift,
                                          // [55:29] code_bits, [60:56] code_count
  output logic             m_axis_tlast   // last_token
);

  lzhc_pkg::item_t in_item, q_item;
  lzhc_pkg::tok_t  tok;
  logic            q_valid, q_pop, em_push, em_ready;

  assign in_item.data = s_axis_tdata;
  assign in_item.last = s_axis_tlast;

  lzhc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  lzhc_engine #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .MAX_MATCH   (MAX_MATCH)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .em_push  (em_push),
    .em_ready (em_ready),
    .tok      (tok)
  );

  lzhc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .em_push   (em_push),
    .em_ready  (em_ready),
    .tok       (tok),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  a_lit_clean: assert property (@(posedge clk) disable iff (rst)
    em_push && tok.kind == lzhc_pkg::TOK_LIT |-> tok.len == '0 && tok.shift == '0)
    else $error("literal token carries match fields");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    em_push && tok.kind == lzhc_pkg::TOK_MATCH |->
      tok.len >= 8'd2 && tok.len <= 8'(MAX_MATCH))
    else $error("match length out of range");

  a_push_gap: assert property (@(posedge clk) disable iff (rst)
    em_push |=> !em_push)
    else $error("tokens pushed in consecutive cycles");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for lz_hash_chain_encoder: byte streams go in, tokens are
// predicted by a scoreboard that tracks the window, pair heads and chains itself.
// Depends on lzhc_pkg and the encoder RTL.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN        = lzhc_pkg::DEF_WINDOW_SIZE;
  localparam int WATCH_MAX  = 8000000;
  localparam int ITEM_GOAL  = 1850;
  localparam int HOLD_LEN   = 3000;

  class lz_scoreboard;
    typedef struct {
      logic        kind;
      logic [7:0]  lit;
      logic [7:0]  len;
      logic [11:0] shift;
      logic [26:0] bits;
      logic [4:0]  cnt;
      logic        last;
    } token_s;

    localparam int unsigned WM    = WIN - 1;
    localparam int unsigned SLIM  = WIN - lzhc_pkg::DEF_MAX_MATCH - 1;
    localparam int unsigned CAP   = 4 * WIN;

    token_s      expected_tokens[$];
    bit [7:0]    win[WIN];
    bit [11:0]   head[lzhc_pkg::PAIR_TABLE_SIZE];
    bit [12:0]   chain[WIN];
    int unsigned wp, mstart, mlen, prev, guard;
    bit          mact, first;
    bit [26:0]   cw_bits;
    int unsigned cw_n;
    int          errors, tokens, match_count, longest, far_shift;

    function new();
      wp = 0; mstart = 0; mlen = 0; prev = 0; mact = 0; first = 0;
      errors = 0; tokens = 0; match_count = 0; longest = 0; far_shift = 0;
    endfunction

    function void put(int unsigned v, int unsigned w);
      cw_bits = cw_bits | 27'((v & ((1 << w) - 1)) << cw_n);
      cw_n += w;
    endfunction

    function bit tick();
      bit r;
      r = guard < CAP;
      guard++;
      return r;
    endfunction

    function void code_length(int unsigned l);
      if (l <= 2) put(1, 3);
      else if (l == 3) put(3, 5);
      else if (l == 4) put(5, 3);
      else if (l == 5) put(7, 5);
      else if (l == 6) put(15, 5);
      else if (l <= 10) begin put(11, 4); put(l - 7, 2); end
      else if (l <= 18) begin put(19, 5); put(l - 11, 3); end
      else if (l <= 34) begin put(31, 6); put(l - 19, 4); end
      else if (l <= 98) begin put(23, 5); put(l - 35, 6); end
      else begin put(63, 6); put(l - 99, 7); end
    endfunction

    function void code_shift(int unsigned s);
      if (s < 2) begin put(28, 5); put(s, 1); end
      else if (s < 6) begin put(8, 4); put(s - 2, 2); end
      else if (s < 10) begin put(4, 4); put(s - 6, 2); end
      else if (s < 18) begin put(0, 4); put(s - 10, 3); end
      else if (s < 34) begin put(12, 5); put(s - 18, 4); end
      else if (s < 98) begin put(2, 3); put(s - 34, 6); end
      else if (s < 354) begin put(6, 3); put(s - 98, 8); end
      else if (s < 1378) begin put(3, 2); put(s - 354, 10); end
      else begin put(1, 2); put(s - 1378, 12); end
    endfunction

    function void push_literal(int unsigned b, bit lf);
      token_s t;
      cw_bits = '0; cw_n = 0;
      put(0, 1); put(b & 8'hFF, 8);
      t.kind = lzhc_pkg::TOK_LIT; t.lit = b[7:0]; t.len = '0; t.shift = '0;
      t.bits = cw_bits; t.cnt = 5'(cw_n); t.last = lf;
      expected_tokens.push_back(t);
    endfunction

    function void push_match(int unsigned src, bit lf);
      token_s t;
      int unsigned sh;
      sh = (wp - src - mlen - 1) & WM;
      cw_bits = '0; cw_n = 0;
      code_length(mlen); code_shift(sh);
      t.kind = lzhc_pkg::TOK_MATCH; t.lit = '0; t.len = mlen[7:0]; t.shift = sh[11:0];
      t.bits = cw_bits; t.cnt = 5'(cw_n); t.last = lf;
      expected_tokens.push_back(t);
      mact = 0;
    endfunction

    function bit copies_equal(int unsigned a, int unsigned b, int unsigned n);
      for (int unsigned i = 0; i < n; i++)
        if (win[(a + i) & WM] != win[(b + i) & WM]) return 0;
      return 1;
    endfunction

    // advance the encoder state by one accepted byte and queue its tokens
    function void note_input(bit [7:0] c, bit lf);
      int unsigned h, dif, pprev, sh, s1, rel, cand;
      bit found;
      if (!first) begin
        chain[wp] = 13'(WIN);
        wp = (wp + 1) & WM;
        win[wp] = c;
        prev = c; mact = 0; first = 1;
        if (lf) begin
          push_literal(c, 1);
          first = 0;
        end
        return;
      end
      h = ((prev << 2) ^ c) & (lzhc_pkg::PAIR_TABLE_SIZE - 1);
      dif = (wp - head[h]) & WM;
      if (dif == 0) dif = WIN;
      head[h] = wp[11:0];
      chain[wp] = dif[12:0];
      pprev = wp;
      wp = (wp + 1) & WM;
      win[wp] = c;
      found = 0;
      guard = 0;
      if (!mact) begin
        sh = dif;
        while (sh < SLIM && tick()) begin
          cand = (pprev - sh) & WM;
          if (win[cand] == prev && win[(cand + 1) & WM] == c) begin
            mstart = cand; mlen = 2; mact = 1; found = 1;
            break;
          end
          sh += chain[cand];
        end
        if (!found) push_literal(prev, 0);
      end else if (mlen < lzhc_pkg::DEF_MAX_MATCH) begin
        if (win[(mstart + mlen) & WM] == c) begin
          mlen++;
        end else begin
          rel = wp - mlen;
          s1 = dif;
          sh = ((rel - mstart) & WM) + chain[mstart & WM];
          while (sh < SLIM && tick()) begin
            while (sh > s1 && tick())
              s1 += chain[(pprev - s1) & WM];
            if (sh < s1) begin
              sh += chain[(rel - sh) & WM];
            end else begin
              cand = (rel - sh) & WM;
              if (copies_equal(cand, rel, mlen + 1)) begin
                mstart = cand; mlen++; found = 1;
                break;
              end
              sh += chain[cand];
              s1 += chain[(pprev - s1) & WM];
            end
          end
          if (!found) push_match(mstart, 0);
        end
      end else begin
        push_match(mstart, 0);
      end
      prev = c;
      if (lf) begin
        if (mact) push_match(mstart - 1, 1);
        else push_literal(c, 1);
        first = 0;
        mact = 0;
      end
    endfunction

    function void check(logic [63:0] d, logic l);
      token_s t;
      bit bad;
      if (expected_tokens.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: token with nothing pending: %h last=%b", d, l);
        return;
      end
      t = expected_tokens.pop_front();
      tokens++;
      if (t.kind == lzhc_pkg::TOK_MATCH) begin
        match_count++;
        if (t.len > longest) longest = t.len;
        if (t.shift > far_shift) far_shift = t.shift;
      end
      bad = d[0] !== t.kind || d[8:1] !== t.lit || d[16:9] !== t.len ||
            d[28:17] !== t.shift || d[55:29] !== t.bits || d[60:56] !== t.cnt ||
            l !== t.last;
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: token %0d exp kind=%b lit=%h len=%0d sh=%0d code=%h/%0d last=%b",
                   tokens, t.kind, t.lit, t.len, t.shift, t.bits, t.cnt, t.last);
          $display("       got kind=%b lit=%h len=%0d sh=%0d code=%h/%0d last=%b",
                   d[0], d[8:1], d[16:9], d[28:17], d[55:29], d[60:56], l);
        end
      end
    endfunction

    function int outstanding();
      return expected_tokens.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;

  lz_scoreboard sb = new();
  int          idle_cycles = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;
  bit          hold_request = 0;
  bit          hold_done = 0;
  int          hold_cnt = 0;
  int          ready_mode = 0;
  int          mode_timer = 0;
  bit [7:0]    sent_hist[$];

  always #1 clk = ~clk;

  lz_hash_chain_encoder dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // predict on input transfers, check on output transfers, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_MAX) begin
        $display("ERROR: no transfer for %0d cycles", WATCH_MAX);
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // receiver: switch between always ready, random and sparse; one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_timer == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_timer <= $urandom_range(20, 300);
      end else begin
        mode_timer <= mode_timer - 1;
      end
      case (ready_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_item(input bit [7:0] b, input bit l);
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= l;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    sent_hist.push_back(b);
    if (sent_hist.size() > 5000) void'(sent_hist.pop_front());
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // kinds: 0 noise, 1 single-byte run, 2 copies of earlier text mixed with small-alphabet and random bytes
  task automatic send_stream(input int len, input int kind);
    int copy_left, copy_dist;
    bit [7:0] b, run_byte, base;
    copy_left = 0;
    copy_dist = 1;
    run_byte = 8'($urandom_range(0, 255));
    base = 8'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      if (kind == 0) begin
        b = 8'($urandom_range(0, 255));
      end else if (kind == 1) begin
        b = run_byte;
      end else begin
        if (copy_left == 0 && sent_hist.size() > 2 && $urandom_range(0, 9) < 7) begin
          copy_dist = ($urandom_range(0, 3) == 0)
                 ? $urandom_range(1, (sent_hist.size() < 4000) ? sent_hist.size() : 4000)
                 : $urandom_range(1, (sent_hist.size() < 64) ? sent_hist.size() : 64);
          copy_left = ($urandom_range(0, 9) == 0) ? $urandom_range(90, 240)
                                                  : $urandom_range(2, 40);
        end
        if (copy_left > 0) begin
          b = sent_hist[sent_hist.size() - copy_dist];
          copy_left--;
        end else if ($urandom_range(0, 1)) begin
          b = 8'(base + $urandom_range(0, 3));
        end else begin
          b = 8'($urandom_range(0, 255));
        end
      end
      send_item(b, i == len - 1);
    end
  endtask

  task automatic random_streams(input int goal);
    int pick;
    while (bytes_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) send_stream($urandom_range(1, 20), 0);
      else if (pick < 14) send_stream($urandom_range(230, 300), 1);
      else send_stream($urandom_range(10, 150), 2);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // two lone bytes, a pair of bytes, a repeated pair, a short run, extreme values
    send_item(8'hFF, 1);
    send_item(8'h00, 1);
    send_item(8'h41, 0); send_item(8'h42, 1);
    for (int i = 0; i < 6; i++) send_item(i[0] ? 8'h42 : 8'h41, i == 5);
    for (int i = 0; i < 4; i++) send_item(8'h00, i == 3);
    send_item(8'hFF, 0); send_item(8'h80, 0); send_item(8'h7F, 0); send_item(8'h01, 0);
    send_item(8'hFE, 0); send_item(8'hFF, 0); send_item(8'h80, 0); send_item(8'h7F, 1);
    drain();

    hold_request = 1'b1;
    random_streams(ITEM_GOAL / 2);
    drain();
    random_streams(ITEM_GOAL);
    drain();

    $display("Sent %0d bytes; checked %0d tokens, %0d matches (longest %0d, largest shift %0d)",
             bytes_sent, sb.tokens, sb.match_count, sb.longest, sb.far_shift);
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/lzhc_pkg.sv
rtl/lzhc_queue.sv
rtl/lzhc_engine.sv
rtl/lzhc_emit.sv
rtl/lz_hash_chain_encoder.sv
tb/tb_top.sv
